[rtl/axis_angle_rotation_matrix_top_assert.svh]
// assertion macros for the rotation matrix rtl
// expects signals named clk and rst_n in the scope of use
`ifndef AXIS_ANGLE_ROTATION_MATRIX_TOP_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_TOP_ASSERT_SVH

// same-cycle implication
`define AARM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AARM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/aarm_pkg.sv]
// shared types, constants and tables for the rotation matrix block
// no dependencies
`timescale 1ns / 1ps

package aarm_pkg;

  localparam int TURN_UNITS    = 23040;
  localparam int HALF_UNITS    = 11520;
  localparam int QUARTER_UNITS = 5760;

  // pi in q30 split as HALF_UNITS * PI_Q0 + PI_R0
  localparam int PI_Q0 = 292817;
  localparam int PI_R0 = 7586;

  // reciprocal of HALF_UNITS for the remainder part
  localparam int      DIV_SHIFT = 40;
  localparam longint  DIV_RECIP = (64'd1 << DIV_SHIFT) / HALF_UNITS;

  localparam logic [31:0] GAIN_Q30 = 32'h26DD3B6A;

  typedef enum logic [2:0] {
    EK_DIAG  = 3'd0,
    EK_PLUS  = 3'd1,
    EK_MINUS = 3'd2,
    EK_ZERO  = 3'd3,
    EK_ONE   = 3'd4
  } entry_kind_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_sel_t;

  typedef struct packed {
    entry_kind_t kind;
    axis_sel_t   u;
    axis_sel_t   v;
    axis_sel_t   w;
  } entry_desc_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h3243F6A8;
      5'd1:    r = 32'h1DAC6705;
      5'd2:    r = 32'h0FADBAFC;
      5'd3:    r = 32'h07F56EA6;
      5'd4:    r = 32'h03FEAB76;
      5'd5:    r = 32'h01FFD55B;
      5'd6:    r = 32'h00FFFAAA;
      5'd7:    r = 32'h007FFF55;
      5'd8:    r = 32'h003FFFEA;
      5'd9:    r = 32'h001FFFFD;
      5'd10:   r = 32'h000FFFFF;
      5'd11:   r = 32'h0007FFFF;
      5'd12:   r = 32'h0003FFFF;
      5'd13:   r = 32'h0001FFFF;
      5'd14:   r = 32'h0000FFFF;
      5'd15:   r = 32'h00007FFF;
      5'd16:   r = 32'h00003FFF;
      5'd17:   r = 32'h00001FFF;
      5'd18:   r = 32'h00000FFF;
      5'd19:   r = 32'h000007FF;
      5'd20:   r = 32'h000003FF;
      5'd21:   r = 32'h000001FF;
      5'd22:   r = 32'h000000FF;
      5'd23:   r = 32'h0000007F;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // what each matrix entry is built from: t*u*v plus c, or plus/minus s*w, or a constant zero or one
  function automatic entry_desc_t entry_desc(input logic [3:0] k);
    entry_desc_t d;
    d = '{kind: EK_ZERO, u: AX_X, v: AX_X, w: AX_X};
    case (k)
      4'd0:    d = '{kind: EK_DIAG,  u: AX_X, v: AX_X, w: AX_X};
      4'd1:    d = '{kind: EK_MINUS, u: AX_X, v: AX_Y, w: AX_Z};
      4'd2:    d = '{kind: EK_PLUS,  u: AX_X, v: AX_Z, w: AX_Y};
      4'd4:    d = '{kind: EK_PLUS,  u: AX_X, v: AX_Y, w: AX_Z};
      4'd5:    d = '{kind: EK_DIAG,  u: AX_Y, v: AX_Y, w: AX_X};
      4'd6:    d = '{kind: EK_MINUS, u: AX_Y, v: AX_Z, w: AX_X};
      4'd8:    d = '{kind: EK_MINUS, u: AX_X, v: AX_Z, w: AX_Y};
      4'd9:    d = '{kind: EK_PLUS,  u: AX_Y, v: AX_Z, w: AX_X};
      4'd10:   d = '{kind: EK_DIAG,  u: AX_Z, v: AX_Z, w: AX_X};
      4'd15:   d = '{kind: EK_ONE,   u: AX_X, v: AX_X, w: AX_X};
      default: d = '{kind: EK_ZERO,  u: AX_X, v: AX_X, w: AX_X};
    endcase
    return d;
  endfunction

endpackage

[rtl/aarm_front.sv]
// front end: input buffer, angle folding, degree to radian scaling, cordic
// depends on aarm_pkg
`timescale 1ns / 1ps

module aarm_front import aarm_pkg::*; #(
  parameter int STEPS = 16,
  parameter int FRAC  = 14,
  parameter int CW    = FRAC + 2,
  parameter int TW    = FRAC + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,
  output logic                 push_valid,
  input  logic                 push_ready,
  output logic [47:0]          push_axes,
  output logic signed [CW-1:0] push_c,
  output logic signed [CW-1:0] push_s,
  output logic signed [TW-1:0] push_t
);

  localparam int XW = 34;
  localparam int ZW = 33;
  localparam int IW = $clog2(STEPS);
  localparam logic signed [XW-1:0] RND_X = XW'(1) <<< (29 - FRAC);
  localparam logic signed [TW-1:0] ONE_T = TW'(1) <<< FRAC;

  typedef enum logic [6:0] {
    F_IDLE  = 7'b0000001,
    F_MUL1  = 7'b0000010,
    F_MUL2  = 7'b0000100,
    F_LOAD  = 7'b0001000,
    F_ROT   = 7'b0010000,
    F_ROUND = 7'b0100000,
    F_PUSH  = 7'b1000000
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic              buf_vld_r;
  logic [63:0]       buf_data_r;
  logic [47:0]       axes_r;
  logic [12:0]       mag_r;
  logic              sgn_r;
  logic              neg_r;
  logic [30:0]       p1_r;
  logic [25:0]       v_r;
  logic [11:0]       qe_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [IW-1:0]     i_r;
  logic signed [CW-1:0] c_r, s_r;
  logic signed [TW-1:0] t_r;

  // angle reduction into [-quarter, quarter] turn
  logic signed [16:0] a17, r1, r2, r3;
  logic               fold_neg;
  logic [12:0]        fold_mag;

  always_comb begin
    a17 = {buf_data_r[15], buf_data_r[15:0]};
    r1 = a17;
    if (a17 >= TURN_UNITS) begin
      r1 = a17 - 17'(TURN_UNITS);
    end else if (a17 <= -TURN_UNITS) begin
      r1 = a17 + 17'(TURN_UNITS);
    end
    r2 = r1;
    if (r1 >= HALF_UNITS) begin
      r2 = r1 - 17'(TURN_UNITS);
    end else if (r1 < -HALF_UNITS) begin
      r2 = r1 + 17'(TURN_UNITS);
    end
    r3 = r2;
    fold_neg = 1'b0;
    if (r2 > QUARTER_UNITS) begin
      r3 = r2 - 17'(HALF_UNITS);
      fold_neg = 1'b1;
    end else if (r2 < -QUARTER_UNITS) begin
      r3 = r2 + 17'(HALF_UNITS);
      fold_neg = 1'b1;
    end
    fold_mag = r3[16] ? 13'(-r3) : 13'(r3);
  end

  logic [52:0]          div_prod;
  logic [25:0]          rem;
  logic [30:0]          zmag;
  logic signed [ZW-1:0] zs;

  always_comb begin
    div_prod = {27'b0, v_r} * 53'(DIV_RECIP);
    rem      = v_r - 26'(qe_r) * 26'(HALF_UNITS);
    zmag     = p1_r + 31'(qe_r) + 31'(rem >= 26'(HALF_UNITS));
    zs       = ZW'(zmag);
  end

  // one cordic micro-rotation per cycle
  logic signed [XW-1:0] dx, dy, xf, xr, yf, yr;
  logic signed [ZW-1:0] atz;
  logic signed [CW-1:0] c_nxt;
  logic signed [TW-1:0] c_ext;

  always_comb begin
    dx  = y_r >>> i_r;
    dy  = x_r >>> i_r;
    atz = ZW'(atan_q30(5'(i_r)));
    xf  = neg_r ? -x_r : x_r;
    yf  = neg_r ? -y_r : y_r;
    xr  = (xf + RND_X) >>> (30 - FRAC);
    yr  = (yf + RND_X) >>> (30 - FRAC);
    c_nxt = CW'(xr);
    c_ext = TW'(c_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (buf_vld_r) state_nxt = F_MUL1;
      F_MUL1:  state_nxt = F_MUL2;
      F_MUL2:  state_nxt = F_LOAD;
      F_LOAD:  state_nxt = F_ROT;
      F_ROT:   if (i_r == IW'(STEPS - 1)) state_nxt = F_ROUND;
      F_ROUND: state_nxt = F_PUSH;
      F_PUSH:  if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      buf_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_tvalid && in_tready) begin
        buf_vld_r <= 1'b1;
      end else if (state_r == F_IDLE) begin
        buf_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      buf_data_r <= in_tdata;
    end
    case (state_r)
      F_IDLE: begin
        axes_r <= buf_data_r[63:16];
        mag_r  <= fold_mag;
        sgn_r  <= r3[16];
        neg_r  <= fold_neg;
      end
      F_MUL1: begin
        p1_r <= 31'(mag_r) * 31'(PI_Q0);
        v_r  <= 26'(mag_r) * 26'(PI_R0) + 26'(QUARTER_UNITS);
      end
      F_MUL2: begin
        qe_r <= div_prod[DIV_SHIFT +: 12];
      end
      F_LOAD: begin
        z_r <= sgn_r ? -zs : zs;
        x_r <= XW'(GAIN_Q30);
        y_r <= '0;
        i_r <= '0;
      end
      F_ROT: begin
        i_r <= i_r + IW'(1);
        if (z_r[ZW-1]) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atz;
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atz;
        end
      end
      F_ROUND: begin
        c_r <= c_nxt;
        s_r <= CW'(yr);
        t_r <= ONE_T - c_ext;
      end
      default: ;
    endcase
  end

  assign in_tready  = !buf_vld_r;
  assign push_valid = (state_r == F_PUSH);
  assign push_axes  = axes_r;
  assign push_c     = c_r;
  assign push_s     = s_r;
  assign push_t     = t_r;

endmodule

[rtl/aarm_queue.sv]
// two-entry queue between the cordic front and the matrix back end
// no dependencies
`timescale 1ns / 1ps

module aarm_queue #(
  parameter int W = 96
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= !wr_ptr_r;
      if (do_rd) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/aarm_back.sv]
// back end: walks the sixteen matrix entries through a three-stage datapath
// depends on aarm_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "axis_angle_rotation_matrix_top_assert.svh"

module aarm_back import aarm_pkg::*; #(
  parameter int FRAC = 14,
  parameter int CW   = FRAC + 2,
  parameter int TW   = FRAC + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic [47:0]          q_axes,
  input  logic signed [CW-1:0] q_c,
  input  logic signed [CW-1:0] q_s,
  input  logic signed [TW-1:0] q_t,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [3:0]           out_index,
  output logic signed [16:0]   out_value,
  output logic                 out_last
);

  localparam int EW = FRAC + 34;
  localparam logic signed [EW-1:0] RND_E = EW'(1) <<< (FRAC + 13);

  logic en, issue;
  logic [3:0] k_r;
  entry_desc_t d;
  logic signed [15:0] ax, ay, az, u, v, w;
  logic signed [TW+15:0] tu_nxt;
  logic signed [CW+15:0] sw_nxt;

  assign en    = !out_tvalid || out_tready;
  assign issue = q_valid && en;
  assign q_ready = en && (k_r == 4'd15);

  function automatic logic signed [15:0] pick(input axis_sel_t sel,
      input logic signed [15:0] px, input logic signed [15:0] py,
      input logic signed [15:0] pz);
    logic signed [15:0] r;
    case (sel)
      AX_X:    r = px;
      AX_Y:    r = py;
      AX_Z:    r = pz;
      default: r = px;
    endcase
    return r;
  endfunction

  always_comb begin
    ax = q_axes[15:0];
    ay = q_axes[31:16];
    az = q_axes[47:32];
    d  = entry_desc(k_r);
    u  = pick(d.u, ax, ay, az);
    v  = pick(d.v, ax, ay, az);
    w  = pick(d.w, ax, ay, az);
    tu_nxt = q_t * u;
    sw_nxt = q_s * w;
  end

  // stage 1: t*u and s*w
  logic                  vld1_r;
  logic [3:0]            k1_r;
  entry_kind_t           kind1_r;
  logic signed [TW+15:0] tu1_r;
  logic signed [CW+15:0] sw1_r;
  logic signed [CW-1:0]  c1_r;
  logic signed [15:0]    v1_r;

  // stage 2: exact entry value
  logic                  vld2_r;
  logic [3:0]            k2_r;
  entry_kind_t           kind2_r;
  logic signed [EW-1:0]  e2_r;

  logic signed [EW-1:0] tuv, c_e, sw_e, e_nxt, rnd, q;
  logic signed [16:0]   val_nxt;

  always_comb begin
    tuv  = tu1_r * v1_r;
    c_e  = EW'(c1_r);
    sw_e = EW'(sw1_r);
    case (kind1_r)
      EK_DIAG:  e_nxt = tuv + (c_e <<< 28);
      EK_PLUS:  e_nxt = tuv + (sw_e <<< 14);
      EK_MINUS: e_nxt = tuv - (sw_e <<< 14);
      default:  e_nxt = '0;
    endcase
    rnd = e2_r + RND_E;
    q   = rnd >>> (FRAC + 14);
    if (q > 65535) begin
      val_nxt = 17'sd65535;
    end else if (q < -65536) begin
      val_nxt = -17'sd65536;
    end else begin
      val_nxt = 17'(q);
    end
    case (kind2_r)
      EK_ZERO: val_nxt = '0;
      EK_ONE:  val_nxt = 17'sd16384;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= 4'd0;
      vld1_r     <= 1'b0;
      vld2_r     <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      if (issue) k_r <= k_r + 4'd1;
      vld1_r     <= issue;
      vld2_r     <= vld1_r;
      out_tvalid <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1_r      <= k_r;
      kind1_r   <= d.kind;
      tu1_r     <= tu_nxt;
      sw1_r     <= sw_nxt;
      c1_r      <= q_c;
      v1_r      <= v;
      k2_r      <= k1_r;
      kind2_r   <= kind1_r;
      e2_r      <= e_nxt;
      out_index <= k2_r;
      out_value <= val_nxt;
      out_last  <= (k2_r == 4'd15);
    end
  end

  `AARM_ASSERT_NEXT(a_idx_after_last, out_tvalid && out_tready && out_last,
    !out_tvalid || out_index == 4'd0, "entry after the last one is not entry 0")
  `AARM_ASSERT_NEXT(a_idx_step, out_tvalid && out_tready && !out_last,
    !out_tvalid || out_index == $past(out_index) + 4'd1, "entry index skipped")
  `AARM_ASSERT_SAME(a_stage_order, vld2_r && out_tvalid,
    k2_r == out_index + 4'd1, "pipeline stages out of order")

endmodule

[rtl/axis_angle_rotation_matrix_top.sv]
// axis-angle to 4x4 rotation matrix, top level
// depends on aarm_pkg, aarm_front, aarm_queue, aarm_back
`timescale 1ns / 1ps
//
// usage:
//   in_* channel: one transfer carries an angle (q9.6 degrees) and a rotation
//   axis (q1.14 x, y, z). the axis is used as given, not normalized.
//   out_* channel: sixteen transfers per input, matrix entries 0..15 in
//   array order, each with its index and a q2.14 value; tlast marks entry 15.
// flow: the back end emits one entry per cycle while out_tready is high;
//   the cordic front works on one item at a time, one micro-rotation a
//   cycle, and runs ahead into a two-entry queue; its input buffer can
//   take the next item while the front works on the last one.
// reset: synchronous, active low; clears all valids and the queue.
// stall: when out_tready is low the output stage and back pipeline hold,
//   the queue fills, then the front and finally in_tready stop.

module axis_angle_rotation_matrix_top import aarm_pkg::*; #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // angle_deg, axis_x, axis_y, axis_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // element_index, element_value, zero pad
  output logic        out_tlast
);

  localparam int CW = FRACTION_BITS + 2;
  localparam int TW = FRACTION_BITS + 3;
  localparam int QW = 48 + TW + 2 * CW;

  logic                 push_valid, push_ready;
  logic [47:0]          push_axes;
  logic signed [CW-1:0] push_c, push_s;
  logic signed [TW-1:0] push_t;
  logic                 q_valid, q_ready;
  logic [QW-1:0]        q_data;
  logic [3:0]           idx;
  logic signed [16:0]   val;

  aarm_front #(.STEPS(CORDIC_STEPS), .FRAC(FRACTION_BITS), .CW(CW), .TW(TW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_axes  (push_axes),
    .push_c     (push_c),
    .push_s     (push_s),
    .push_t     (push_t)
  );

  aarm_queue #(.W(QW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_axes, push_t, push_s, push_c}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  aarm_back #(.FRAC(FRACTION_BITS), .CW(CW), .TW(TW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_axes     (q_data[QW-1 -: 48]),
    .q_c        (q_data[CW-1:0]),
    .q_s        (q_data[2*CW-1:CW]),
    .q_t        (q_data[2*CW+TW-1:2*CW]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_index  (idx),
    .out_value  (val),
    .out_last   (out_tlast)
  );

  assign out_tdata = {3'b000, val, idx};

endmodule

[verif/aarm_checker.sv]
// scoreboard for the rotation matrix block: watches both stream channels
// depends on nothing but the port widths of axis_angle_rotation_matrix_top
`timescale 1ns / 1ps

module aarm_checker #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          entries_due
);

  localparam longint TURN    = 23040;
  localparam longint HALF    = 11520;
  localparam longint QUARTER = 5760;
  localparam longint PI_Q30  = 64'd3373259426;
  localparam longint GAIN    = 64'h26DD3B6A;

  localparam longint ATAN [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  typedef struct packed {
    logic [3:0]  idx;
    logic [16:0] val;
    logic        last;
  } matrix_entry_t;

  matrix_entry_t entry_q[$];

  // sine and cosine in q.FRACTION_BITS of an angle in 1/64 degree
  function automatic void angle_sin_cos(input longint ang, output longint sn,
                                        output longint cs);
    longint r, mag, z, x, y, dx, dy;
    bit     neg;
    int     steps;
    r   = ang % TURN;
    neg = 0;
    if (r >= HALF) r -= TURN;
    if (r < -HALF) r += TURN;
    if (r > QUARTER) begin
      r -= HALF;
      neg = 1;
    end else if (r < -QUARTER) begin
      r += HALF;
      neg = 1;
    end
    mag = (r < 0) ? -r : r;
    z   = (mag * PI_Q30 + QUARTER) / HALF;
    if (r < 0) z = -z;
    x = GAIN;
    y = 0;
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN[i];
      end else begin
        x += dx; y -= dy; z += ATAN[i];
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    cs = (x + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
    sn = (y + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
  endfunction

  // exact product sum to saturated q2.14
  function automatic logic [16:0] to_q2_14(input longint v);
    longint q;
    q = (v + (64'sd1 <<< (FRACTION_BITS + 13))) >>> (FRACTION_BITS + 14);
    if (q > 65535) q = 65535;
    if (q < -65536) q = -65536;
    return q[16:0];
  endfunction

  task automatic predict_matrix(input logic [63:0] d);
    longint ang, ax, ay, az, sn, cs, t, cw, sx, sy, sz, txy, txz, tyz;
    longint m [16];
    matrix_entry_t e;
    ang = longint'($signed(d[15:0]));
    ax  = longint'($signed(d[31:16]));
    ay  = longint'($signed(d[47:32]));
    az  = longint'($signed(d[63:48]));
    angle_sin_cos(ang, sn, cs);
    t   = (64'sd1 <<< FRACTION_BITS) - cs;
    cw  = cs <<< 28;
    sx  = sn * ax * 16384;
    sy  = sn * ay * 16384;
    sz  = sn * az * 16384;
    txy = t * ax * ay;
    txz = t * ax * az;
    tyz = t * ay * az;
    m = '{default: 0};
    m[0]  = t * ax * ax + cw;
    m[1]  = txy - sz;
    m[2]  = txz + sy;
    m[4]  = txy + sz;
    m[5]  = t * ay * ay + cw;
    m[6]  = tyz - sx;
    m[8]  = txz - sy;
    m[9]  = tyz + sx;
    m[10] = t * az * az + cw;
    m[15] = 64'sd1 <<< (FRACTION_BITS + 28);
    for (int k = 0; k < 16; k++) begin
      e.idx  = k[3:0];
      e.val  = to_q2_14(m[k]);
      e.last = (k == 15);
      entry_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    matrix_entry_t e;
    if (!rst_n) begin
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) predict_matrix(in_tdata);
      if (out_tvalid && out_tready) begin
        if (entry_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected entry, expected none, actual idx %0d val %0d last %0b",
                   $time, out_tdata[3:0], $signed(out_tdata[20:4]), out_tlast);
        end else begin
          e = entry_q.pop_front();
          if (out_tdata[3:0] !== e.idx) begin
            fail_count++;
            $display("%0t: index mismatch, expected %0d, actual %0d",
                     $time, e.idx, out_tdata[3:0]);
          end
          if (out_tdata[20:4] !== e.val) begin
            fail_count++;
            $display("%0t: value mismatch at idx %0d, expected %0d, actual %0d",
                     $time, e.idx, $signed(e.val), $signed(out_tdata[20:4]));
          end
          if (out_tlast !== e.last) begin
            fail_count++;
            $display("%0t: tlast mismatch at idx %0d, expected %0b, actual %0b",
                     $time, e.idx, e.last, out_tlast);
          end
        end
      end
    end
    entries_due = entry_q.size();
  end

endmodule

[verif/tb_axis_angle_rotation_matrix_top.sv]
// stimulus and verdict for the rotation matrix block
// depends on axis_angle_rotation_matrix_top and aarm_checker
`timescale 1ns / 1ps

module tb_axis_angle_rotation_matrix_top;

  localparam logic [15:0] ONE_Q14 = 16'd16384;
  localparam logic [15:0] NEG_ONE_Q14 = 16'hC000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  int fail_count;
  int entries_due;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;

  always #10 clk = ~clk;

  axis_angle_rotation_matrix_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  aarm_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .fail_count(fail_count), .entries_due(entries_due)
  );

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_rotation(input logic [15:0] ang, input logic [15:0] x,
                               input logic [15:0] y, input logic [15:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x, ang};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly axes within unit range, some full 16-bit noise
  task automatic send_random;
    logic [15:0] x, y, z;
    if ($urandom_range(99) < 80) begin
      x = 16'($signed($urandom_range(32768)) - 16384);
      y = 16'($signed($urandom_range(32768)) - 16384);
      z = 16'($signed($urandom_range(32768)) - 16384);
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
      z = 16'($urandom);
    end
    send_rotation(16'($urandom), x, y, z);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // quarter turns, half turn, full turn, range ends, odd angles
    send_rotation(16'd0,     ONE_Q14, 16'd0, 16'd0);
    send_rotation(16'd5760,  16'd0, ONE_Q14, 16'd0);
    send_rotation(16'hE980,  16'd0, 16'd0, ONE_Q14);
    send_rotation(16'd11520, NEG_ONE_Q14, 16'd0, 16'd0);
    send_rotation(16'hD300,  16'd0, NEG_ONE_Q14, 16'd0);
    send_rotation(16'd23040, 16'd0, 16'd0, NEG_ONE_Q14);
    send_rotation(16'h7FFF,  16'd9459, 16'd9459, 16'd9459);
    send_rotation(16'h8000,  16'd9459, 16'hDB0D, 16'd9459);
    send_rotation(16'd2880,  16'd11585, 16'd11585, 16'd0);
    send_rotation(16'd5761,  16'd0, 16'd11585, 16'hD2BF);
    send_rotation(16'd17280, ONE_Q14, ONE_Q14, ONE_Q14);
    send_rotation(16'd1,     16'd0, 16'd0, 16'd0);
    // overlong axes drive entries into saturation
    send_rotation(16'd0,     16'h8000, 16'h8000, 16'h8000);
    send_rotation(16'd5760,  16'h7FFF, 16'h8000, 16'h7FFF);
    send_rotation(16'd11520, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_rotation(16'hF000,  16'h8000, 16'h7FFF, 16'h0001);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_req = 1; end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      for (int n = 0; n < 111; n++) send_random();
    end
    in_tvalid <= 1'b0;

    while (entries_due != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
